// File: sv/uniform_grid_linear_interpolator_top_defines.svh
// Assertion macros shared by the interpolator RTL.
`ifndef UNIFORM_GRID_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`define UNIFORM_GRID_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UGLI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define UGLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ugli_pkg.sv
package ugli_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 31;
    localparam int PTS_W   = 11;
    localparam int FRAC_W  = 16;

    localparam logic [CFG_W-1:0] OFFSET_RESET  = 31'd0;
    localparam logic [CFG_W-1:0] INV_SP_RESET  = 31'd65536;
    localparam logic [PTS_W-1:0] POINTS_RESET  = 11'd1024;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_GRID_OFFSET     = 2'd0,
        CFG_GRID_SPACING    = 2'd1,
        CFG_INVERSE_SPACING = 2'd2,
        CFG_POINTS_IN_USE   = 2'd3
    } cfg_index_t;

endpackage

// File: sv/uniform_grid_linear_interpolator_top.sv
// An accepted request moves through the pipeline stages in order; the last stage drives its result on m_tvalid.
// Throughput: one request per cycle; each stage stalls only while its successor is full.
// The two table reads per point use the two read ports of the table memory in stage four.
// Reset (aresetn low, synchronous) empties the pipeline and restores the register defaults.
// The table itself is not cleared; an entry must be written before a point reads it.
`include "uniform_grid_linear_interpolator_top_defines.svh"

module uniform_grid_linear_interpolator_top
    import ugli_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_tvalid,
    output logic             s_tready,
    // [9:0] entry_index, [41:10] entry_value, [73:42] point, [79:74] zero
    input  logic [79:0]      s_tdata,
    // [0] cmd
    input  logic [0:0]       s_tuser,

    output logic             m_tvalid,
    input  logic             m_tready,
    // [31:0] potential
    output logic [31:0]      m_tdata,
    // [0] clamped
    output logic [0:0]       m_tuser,

    input  logic             cfg_wr_en,
    input  cfg_index_t       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW + 1 > PTS_W) ? AW + 1 : PTS_W;
    localparam int NSTAGE = 7;

    // Configuration registers. The grid spacing has no bearing on the result,
    // since the inverse spacing replaces the division, so it is not stored.
    logic [CFG_W-1:0] offset_reg;
    logic [CFG_W-1:0] inv_sp_reg;
    logic [PTS_W-1:0] points_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= OFFSET_RESET;
            inv_sp_reg <= INV_SP_RESET;
            points_reg <= POINTS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_GRID_OFFSET:     offset_reg <= cfg_wdata;
                CFG_GRID_SPACING:    ;
                CFG_INVERSE_SPACING: inv_sp_reg <= cfg_wdata;
                CFG_POINTS_IN_USE:   points_reg <= cfg_wdata[PTS_W-1:0];
                default:             ;
            endcase
        end
    end

    // Pipeline flow control: a stage takes new data when it is empty or when
    // its own content moves on in the same cycle.
    logic [NSTAGE:1]   valid_reg;
    logic [NSTAGE+1:1] stage_ready;

    always_comb begin
        stage_ready[NSTAGE+1] = m_tready;
        for (int k = NSTAGE; k >= 1; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[1]) begin
                valid_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NSTAGE; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = stage_ready[1];

    // Stage 1: capture the request and shift the point onto the grid.
    logic [INDEX_W-1:0]        s1_index_reg;
    logic [VALUE_W-1:0]        s1_value_reg;
    cmd_t                      s1_cmd_reg;
    logic signed [VALUE_W:0]   s1_pos_reg;
    logic signed [VALUE_W:0]   s1_pos_next;

    assign s1_pos_next = $signed({s_tdata[73], s_tdata[73:42]})
                       + $signed({2'b00, offset_reg});

    always_ff @(posedge aclk) begin
        if (stage_ready[1]) begin
            s1_index_reg <= s_tdata[9:0];
            s1_value_reg <= s_tdata[41:10];
            s1_cmd_reg   <= cmd_t'(s_tuser[0]);
            s1_pos_reg   <= s1_pos_next;
        end
    end

    // Stage 2: scaled position, an unsigned Q31.32 value for points on the grid.
    logic [INDEX_W-1:0]            s2_index_reg;
    logic [VALUE_W-1:0]            s2_value_reg;
    cmd_t                          s2_cmd_reg;
    logic                          s2_neg_reg;
    logic [VALUE_W+CFG_W-1:0]      s2_prod_reg;
    logic [VALUE_W+CFG_W-1:0]      s2_prod_next;

    assign s2_prod_next = s1_pos_reg[VALUE_W-1:0] * inv_sp_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[2]) begin
            s2_index_reg <= s1_index_reg;
            s2_value_reg <= s1_value_reg;
            s2_cmd_reg   <= s1_cmd_reg;
            s2_neg_reg   <= s1_pos_reg[VALUE_W];
            s2_prod_reg  <= s2_prod_next;
        end
    end

    // Stage 3: cell index, end-of-grid test and table addresses.
    logic [CFG_W-1:0]   cell_idx;
    logic [CW-1:0]      pts_ext;
    logic [CW-1:0]      n_clip;
    logic [AW-1:0]      n_last;
    logic               hi_clamp;
    logic [AW-1:0]      s3_addr0_next;

    assign cell_idx = s2_prod_reg[VALUE_W+CFG_W-1:32];
    assign pts_ext  = CW'(points_reg);

    always_comb begin
        if (pts_ext < CW'(2)) begin
            n_clip = CW'(2);
        end else if (pts_ext > CW'(TABLE_DEPTH)) begin
            n_clip = CW'(TABLE_DEPTH);
        end else begin
            n_clip = pts_ext;
        end
        n_last   = AW'(n_clip - CW'(1));
        hi_clamp = cell_idx >= CFG_W'(n_last);
        if (s2_neg_reg) begin
            s3_addr0_next = '0;
        end else if (hi_clamp) begin
            s3_addr0_next = n_last;
        end else begin
            s3_addr0_next = cell_idx[AW-1:0];
        end
    end

    logic [AW-1:0]      s3_waddr_reg;
    logic [VALUE_W-1:0] s3_value_reg;
    logic               s3_wr_ok_reg;
    cmd_t               s3_cmd_reg;
    logic               s3_clamp_reg;
    logic [AW-1:0]      s3_addr0_reg;
    logic [AW-1:0]      s3_addr1_reg;
    logic [FRAC_W-1:0]  s3_frac_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[3]) begin
            s3_waddr_reg <= AW'(s2_index_reg);
            s3_value_reg <= s2_value_reg;
            s3_wr_ok_reg <= 32'(s2_index_reg) < 32'(TABLE_DEPTH);
            s3_cmd_reg   <= s2_cmd_reg;
            s3_clamp_reg <= s2_neg_reg || hi_clamp;
            s3_addr0_reg <= s3_addr0_next;
            s3_addr1_reg <= cell_idx[AW-1:0] + AW'(1);
            s3_frac_reg  <= s2_prod_reg[31:16];
        end
    end

    // Stage 4: table memory. Writes and reads are both issued from stage 3,
    // so a point always sees every write that was requested before it.
    logic [VALUE_W-1:0] tbl_mem [TABLE_DEPTH];
    logic               tbl_we;
    logic signed [VALUE_W-1:0] s4_rd0_reg;
    logic signed [VALUE_W-1:0] s4_rd1_reg;
    cmd_t               s4_cmd_reg;
    logic               s4_clamp_reg;
    logic [FRAC_W-1:0]  s4_frac_reg;

    assign tbl_we = stage_ready[4] && valid_reg[3] && (s3_cmd_reg == CMD_WRITE) && s3_wr_ok_reg;

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[s3_waddr_reg] <= s3_value_reg;
        end
        if (stage_ready[4]) begin
            s4_rd0_reg <= tbl_mem[s3_addr0_reg];
            s4_rd1_reg <= tbl_mem[s3_addr1_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[4]) begin
            s4_cmd_reg   <= s3_cmd_reg;
            s4_clamp_reg <= s3_clamp_reg;
            s4_frac_reg  <= s3_frac_reg;
        end
    end

    // Stage 5: difference between neighbouring entries.
    logic signed [VALUE_W-1:0] s5_v0_reg;
    logic signed [VALUE_W:0]   s5_diff_reg;
    logic signed [VALUE_W:0]   s5_diff_next;
    cmd_t               s5_cmd_reg;
    logic               s5_clamp_reg;
    logic [FRAC_W-1:0]  s5_frac_reg;

    assign s5_diff_next = s4_rd1_reg - s4_rd0_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[5]) begin
            s5_v0_reg    <= s4_rd0_reg;
            s5_diff_reg  <= s5_diff_next;
            s5_cmd_reg   <= s4_cmd_reg;
            s5_clamp_reg <= s4_clamp_reg;
            s5_frac_reg  <= s4_frac_reg;
        end
    end

    // Stage 6: difference times fraction, a signed Q33.16 product.
    localparam int PROD_W = VALUE_W + 1 + FRAC_W;

    logic signed [PROD_W:0]    prod_full;
    logic signed [VALUE_W-1:0] s6_v0_reg;
    logic signed [PROD_W-1:0]  s6_prod_reg;
    cmd_t               s6_cmd_reg;
    logic               s6_clamp_reg;

    assign prod_full = s5_diff_reg * $signed({1'b0, s5_frac_reg});

    always_ff @(posedge aclk) begin
        if (stage_ready[6]) begin
            s6_v0_reg    <= s5_v0_reg;
            s6_prod_reg  <= prod_full[PROD_W-1:0];
            s6_cmd_reg   <= s5_cmd_reg;
            s6_clamp_reg <= s5_clamp_reg;
        end
    end

    // Stage 7: add, saturate and select the result. The arithmetic shift of
    // the product rounds toward minus infinity.
    logic signed [VALUE_W:0]   step;
    logic signed [VALUE_W+1:0] sum;
    logic [VALUE_W-1:0]        sat_val;
    logic [VALUE_W-1:0]        out_potential_next;
    logic                      out_clamped_next;
    logic [VALUE_W-1:0]        out_potential_reg;
    logic                      out_clamped_reg;

    assign step = s6_prod_reg[PROD_W-1:FRAC_W];
    assign sum  = s6_v0_reg + step;

    always_comb begin
        if (sum[VALUE_W+1:VALUE_W-1] == 3'b000 || sum[VALUE_W+1:VALUE_W-1] == 3'b111) begin
            sat_val = sum[VALUE_W-1:0];
        end else if (sum[VALUE_W+1]) begin
            sat_val = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(VALUE_W-1){1'b1}}};
        end

        if (s6_cmd_reg == CMD_WRITE) begin
            out_potential_next = '0;
            out_clamped_next   = 1'b0;
        end else if (s6_clamp_reg) begin
            out_potential_next = s6_v0_reg;
            out_clamped_next   = 1'b1;
        end else begin
            out_potential_next = sat_val;
            out_clamped_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[7]) begin
            out_potential_reg <= out_potential_next;
            out_clamped_reg   <= out_clamped_next;
        end
    end

    assign m_tvalid = valid_reg[NSTAGE];
    assign m_tdata  = out_potential_reg;
    assign m_tuser  = out_clamped_reg;

    `UGLI_ASSERT_NEXT(a_accept_fills_stage1, s_tvalid && s_tready, valid_reg[1],
        "accepted request did not reach stage 1")
    `UGLI_ASSERT_NEXT(a_stage5_holds, valid_reg[5] && !stage_ready[5],
        valid_reg[5] && $stable(s5_frac_reg), "stalled stage 5 lost its content")
    `UGLI_ASSERT_NOW(a_cell_addresses,
        valid_reg[3] && (s3_cmd_reg == CMD_EVAL) && !s3_clamp_reg,
        s3_addr1_reg == s3_addr0_reg + AW'(1), "interpolation reads are not adjacent")

endmodule

// File: sim/uniform_grid_linear_interpolator_top_test.sv
`timescale 1ns / 1ps

module uniform_grid_linear_interpolator_top_test;
    import ugli_pkg::*;

    localparam int TABLE_DEPTH   = DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_CYCLES  = 300;
    localparam longint WORD_MAX  = 64'sd2147483647;
    localparam longint WORD_MIN  = -64'sd2147483647 - 64'sd1;

    typedef struct packed {
        logic [VALUE_W-1:0] potential;
        logic               clamped;
    } interp_result_t;

    typedef enum int {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FULL_RATE
    } pacing_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [79:0]      s_tdata;
    logic [0:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [31:0]      m_tdata;
    logic [0:0]       m_tuser;
    logic             cfg_wr_en;
    cfg_index_t       cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;

    // Local copy of the table and registers, updated as requests are accepted.
    logic [VALUE_W-1:0] potential_store [TABLE_DEPTH];
    bit                 entry_loaded [TABLE_DEPTH];
    logic [CFG_W-1:0]   grid_offset_q;
    logic [CFG_W-1:0]   grid_spacing_q;
    logic [CFG_W-1:0]   inverse_spacing_q;
    logic [PTS_W-1:0]   points_in_use_q;

    interp_result_t awaited_results [$];

    int sender_idle_pct;
    int receiver_idle_pct;
    bit hold_off_requested;
    int hold_left;
    int requests_sent;
    int results_checked;
    int clamped_results;
    int mismatch_count;

    uniform_grid_linear_interpolator_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int grid_points();
        int n;
        n = int'(points_in_use_q);
        if (n < 2) begin
            n = 2;
        end else if (n > TABLE_DEPTH) begin
            n = TABLE_DEPTH;
        end
        return n;
    endfunction

    function automatic interp_result_t interpolate_point(logic [31:0] x);
        interp_result_t r;
        longint         shifted;
        longint         v0;
        longint         v1;
        longint         sum;
        logic [63:0]    scaled;
        int             n;
        int             c;
        n         = grid_points();
        shifted   = longint'($signed(x)) + longint'(grid_offset_q);
        r.clamped = 1'b1;
        if (shifted < 0) begin
            r.potential = potential_store[0];
        end else begin
            scaled = 64'(shifted) * 64'(inverse_spacing_q);
            if (scaled[63:32] >= 32'(n - 1)) begin
                r.potential = potential_store[n-1];
            end else begin
                c  = int'(scaled[41:32]);
                v0 = longint'($signed(potential_store[c]));
                v1 = longint'($signed(potential_store[c+1]));
                // An arithmetic shift of the signed product rounds towards minus infinity.
                sum = v0 + (((v1 - v0) * longint'(scaled[31:16])) >>> 16);
                if (sum > WORD_MAX) begin
                    sum = WORD_MAX;
                end else if (sum < WORD_MIN) begin
                    sum = WORD_MIN;
                end
                r.potential = sum[31:0];
                r.clamped   = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] random_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return 32'h8000_0000;
        end else if (sel == 1) begin
            return 32'h7FFF_FFFF;
        end
        return $urandom;
    endfunction

    // Most points are aimed at a chosen cell so that the interior, the exact grid
    // points and both ends are reached whatever the offset and scale.
    function automatic logic [31:0] make_point();
        int     n;
        int     sel;
        longint target;
        longint shifted;
        longint x;
        n   = grid_points();
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            return $urandom;
        end
        if (sel < 25) begin
            x = -longint'(grid_offset_q) - longint'($urandom_range(1, 1 << 20));
        end else begin
            target = longint'($urandom_range(0, n)) << 32;
            if (sel >= 40) begin
                target = target + longint'($urandom);
            end
            if (inverse_spacing_q == '0) begin
                shifted = longint'($urandom_range(0, 1 << 24));
            end else begin
                shifted = (target + longint'(inverse_spacing_q) - 1)
                          / longint'(inverse_spacing_q);
            end
            x = shifted - longint'(grid_offset_q);
        end
        if (x > WORD_MAX || x < WORD_MIN) begin
            return $urandom;
        end
        return x[31:0];
    endfunction

    task automatic set_pacing(pacing_t pace);
        case (pace)
            PACE_SLOW_SINK: begin
                sender_idle_pct   = 38;
                receiver_idle_pct = 81;
            end
            PACE_SLOW_SOURCE: begin
                sender_idle_pct   = 81;
                receiver_idle_pct = 38;
            end
            default: begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
        endcase
    endtask

    task automatic send_request(cmd_t cmd, logic [INDEX_W-1:0] idx,
                                logic [31:0] value, logic [31:0] x);
        interp_result_t r;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, x, value, idx};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_WRITE) begin
            potential_store[idx] = value;
            entry_loaded[idx]    = 1'b1;
            r.potential          = '0;
            r.clamped            = 1'b0;
        end else begin
            r = interpolate_point(x);
        end
        awaited_results.push_back(r);
        requests_sent++;
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(cfg_index_t which, logic [CFG_W-1:0] value);
        drain_pipeline();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= which;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (which)
            CFG_GRID_OFFSET:     grid_offset_q     = value;
            CFG_GRID_SPACING:    grid_spacing_q    = value;
            CFG_INVERSE_SPACING: inverse_spacing_q = value;
            CFG_POINTS_IN_USE:   points_in_use_q   = value[PTS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [CFG_W-1:0] offset, logic [CFG_W-1:0] spacing,
                            logic [CFG_W-1:0] inverse, logic [CFG_W-1:0] points);
        write_register(CFG_GRID_OFFSET, offset);
        write_register(CFG_GRID_SPACING, spacing);
        write_register(CFG_INVERSE_SPACING, inverse);
        write_register(CFG_POINTS_IN_USE, points);
    endtask

    // Every entry a point can reach must hold a value before any point is sent.
    task automatic load_grid();
        for (int i = 0; i < grid_points(); i++) begin
            if (!entry_loaded[i]) begin
                send_request(CMD_WRITE, INDEX_W'(i), random_word(), $urandom);
            end
        end
    endtask

    task automatic send_mix(int count, int write_pct);
        int                 n;
        logic [INDEX_W-1:0] idx;
        n = grid_points();
        repeat (count) begin
            if ($urandom_range(0, 99) < write_pct) begin
                if ($urandom_range(0, 2) == 0) begin
                    idx = INDEX_W'($urandom);
                end else begin
                    idx = INDEX_W'($urandom_range(0, n - 1));
                end
                send_request(CMD_WRITE, idx, random_word(), $urandom);
            end else begin
                send_request(CMD_EVAL, INDEX_W'($urandom), $urandom, make_point());
            end
        end
    endtask

    task automatic test_directed_cases();
        set_pacing(PACE_SLOW_SINK);
        set_grid(31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd4);
        send_request(CMD_WRITE, 10'd0, 32'h8000_0000, 32'h0);
        send_request(CMD_WRITE, 10'd1, 32'h7FFF_FFFF, 32'h0);
        send_request(CMD_WRITE, 10'd2, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(CMD_WRITE, 10'd3, 32'hFFFF_FFFF, 32'h0);
        send_request(CMD_WRITE, 10'd1023, 32'hA5A5_5A5A, 32'h0);
        // Below the grid, on the first point, inside the cells, on and past the last point.
        send_request(CMD_EVAL, 10'd0, 32'h0, 32'h8000_0000);
        send_request(CMD_EVAL, 10'd0, 32'h0, 32'hFFFF_FFFF);
        send_request(CMD_EVAL, 10'd0, 32'h0, 32'h0000_0000);
        send_request(CMD_EVAL, 10'h3FF, 32'hFFFF_FFFF, 32'h0000_8000);
        send_request(CMD_EVAL, 10'd0, 32'h0, 32'h0001_FFFF);
        send_request(CMD_EVAL, 10'd0, 32'h0, 32'h0002_8000);
        send_request(CMD_EVAL, 10'd0, 32'h0, 32'h0003_0000);
        send_request(CMD_EVAL, 10'd0, 32'h0, 32'h7FFF_FFFF);
        send_request(CMD_EVAL, 10'd0, 32'h0, 32'h0002_FFFF);
        // A point straight after a write to the entry it reads.
        send_request(CMD_WRITE, 10'd2, 32'h1234_5678, 32'h0);
        send_request(CMD_EVAL, 10'd0, 32'h0, 32'h0002_4000);
        // With a zero scale every point on the grid side lands on the first entry.
        write_register(CFG_INVERSE_SPACING, 31'd0);
        send_request(CMD_EVAL, 10'd0, 32'h0, 32'h7FFF_FFFF);
        send_request(CMD_EVAL, 10'd0, 32'h0, 32'hFFFF_0000);
        // Point counts below two behave as two.
        write_register(CFG_INVERSE_SPACING, 31'd65536);
        write_register(CFG_POINTS_IN_USE, 31'd0);
        send_request(CMD_EVAL, 10'd0, 32'h0, 32'h0001_8000);
        send_request(CMD_EVAL, 10'd0, 32'h0, 32'h0000_8000);
        write_register(CFG_POINTS_IN_USE, 31'd1);
        send_request(CMD_EVAL, 10'd0, 32'h0, 32'h0001_0000);
        drain_pipeline();
    endtask

    task automatic test_small_grids();
        logic [CFG_W-1:0] offset;
        logic [CFG_W-1:0] spacing;
        logic [CFG_W-1:0] inverse;
        logic [CFG_W-1:0] points;
        for (int k = 0; k < 6; k++) begin
            set_pacing(pacing_t'(k / 2));
            offset  = CFG_W'($urandom_range(0, 32'h7FFF_FFFF));
            spacing = CFG_W'($urandom_range(1, 32'h7FFF_FFFF));
            inverse = CFG_W'($urandom_range(32'h1000, 32'h40_0000));
            points  = CFG_W'($urandom_range(2, 64));
            case (k)
                0: begin
                    offset  = 31'd0;
                    inverse = 31'd65536;
                    points  = 31'd16;
                end
                1: begin
                    offset  = 31'h7FFF_FFFF;
                    spacing = 31'd1;
                    inverse = 31'h7FFF_FFFF;
                    points  = 31'd32;
                end
                2: begin
                    spacing = 31'h7FFF_FFFF;
                    inverse = 31'd1;
                    points  = 31'd8;
                end
                4: begin
                    offset  = 31'h0040_0000;
                    spacing = 31'h0000_1000;
                    inverse = 31'h0010_0000;
                    points  = 31'd64;
                end
                5: begin
                    inverse = 31'd0;
                    points  = 31'd5;
                end
                default: ;
            endcase
            set_grid(offset, spacing, inverse, points);
            load_grid();
            send_mix(70, 20);
            drain_pipeline();
        end
    endtask

    task automatic test_full_table();
        set_pacing(PACE_FULL_RATE);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            send_request(CMD_WRITE, INDEX_W'(i), random_word(), $urandom);
        end
        // Point counts above the depth behave as the full table.
        set_pacing(PACE_SLOW_SINK);
        set_grid(31'h0200_0000, 31'd65536, 31'd65536, 31'd2047);
        send_mix(80, 20);
        set_pacing(PACE_SLOW_SOURCE);
        set_grid(31'd0, 31'h0000_0800, 31'h0020_0000, 31'd1024);
        send_mix(80, 20);
        set_pacing(PACE_FULL_RATE);
        set_grid(CFG_W'($urandom_range(0, 32'h7FFF_FFFF)), 31'd65536,
                 CFG_W'($urandom_range(1, 32'h7FFF_FFFF)),
                 CFG_W'($urandom_range(100, 1024)));
        send_mix(80, 20);
        drain_pipeline();
    endtask

    task automatic test_output_stall();
        set_pacing(PACE_FULL_RATE);
        set_grid(31'h0001_0000, 31'd65536, 31'd65536, 31'd8);
        // The sink holds off for a long stretch while requests keep coming, so the
        // pipeline fills and s_tready must fall.
        hold_off_requested = 1'b1;
        send_mix(60, 20);
        drain_pipeline();
    endtask

    task automatic check_result(logic [31:0] potential, logic clamped);
        interp_result_t r;
        if (awaited_results.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: result with none awaited, expected nothing, actual %h/%0b",
                     $time, potential, clamped);
        end else begin
            r = awaited_results.pop_front();
            if (potential !== r.potential) begin
                mismatch_count++;
                $display("%0t ns: potential mismatch, expected %h, actual %h",
                         $time, r.potential, potential);
            end
            if (clamped !== r.clamped) begin
                mismatch_count++;
                $display("%0t ns: clamped mismatch, expected %0b, actual %0b",
                         $time, r.clamped, clamped);
            end
            if (r.clamped) begin
                clamped_results++;
            end
            results_checked++;
        end
    endtask

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                check_result(m_tdata, m_tuser[0]);
            end
            if (hold_off_requested) begin
                hold_off_requested = 1'b0;
                hold_left          = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_GRID_OFFSET;
        cfg_wdata <= '0;
        grid_offset_q      = OFFSET_RESET;
        grid_spacing_q     = 31'd65536;
        inverse_spacing_q  = INV_SP_RESET;
        points_in_use_q    = POINTS_RESET;
        hold_off_requested = 1'b0;
        hold_left          = 0;
        set_pacing(PACE_SLOW_SINK);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_small_grids();
        test_full_table();
        test_output_stall();

        drain_pipeline();
        repeat (20) @(posedge aclk);
        $display("Summary: %0d requests sent, %0d results checked, %0d clamped to a grid end.",
                 requests_sent, results_checked, clamped_results);
        $display("Summary: whole table loaded, point counts 0 to 2047, long output stall done.");
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/ugli_pkg.sv
sv/uniform_grid_linear_interpolator_top.sv
sim/uniform_grid_linear_interpolator_top_test.sv
